/* rtl/lrf_pkg.sv */
`default_nettype none

package lrf_pkg;

  // Defaults for the top-level parameters
  localparam int FRAME_COUNT_DEF = 8;
  localparam int PAGE_BITS_DEF   = 8;

  // Fixed field widths
  localparam int AGE_W         = 16;
  localparam int FAULT_W       = 16;
  localparam int FRAME_IDX_W   = 3;
  localparam int EV_PAGE_W     = 8;

  localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_POLICY_MODE = '0;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lrf_state_e;

  // Control of the shared compare unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* rtl/lrf_frame_mem.sv */
`default_nettype none

module lrf_frame_mem #(
  parameter int FRAME_COUNT = lrf_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = lrf_pkg::PAGE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic [$clog2(FRAME_COUNT)-1:0] rd_addr_i,
  output logic      [PAGE_BITS-1:0]          rd_page_o,
  output logic      [lrf_pkg::AGE_W-1:0]     rd_age_o,
  input  wire logic                          age_we_i,
  input  wire logic [$clog2(FRAME_COUNT)-1:0] age_waddr_i,
  input  wire logic [lrf_pkg::AGE_W-1:0]     age_wdata_i,
  input  wire logic                          page_we_i,
  input  wire logic [$clog2(FRAME_COUNT)-1:0] page_waddr_i,
  input  wire logic [PAGE_BITS-1:0]          page_wdata_i
);

  logic [PAGE_BITS-1:0]      page_mem [FRAME_COUNT];
  logic [lrf_pkg::AGE_W-1:0] age_mem  [FRAME_COUNT];

  always_ff @(posedge clk_i) begin
    if (page_we_i) begin
      page_mem[page_waddr_i] <= page_wdata_i;
    end
    rd_page_o <= page_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (age_we_i) begin
      age_mem[age_waddr_i] <= age_wdata_i;
    end
    rd_age_o <= age_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

/* rtl/lrf_scan_unit.sv */
`default_nettype none

module lrf_scan_unit #(
  parameter int FRAME_COUNT = lrf_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = lrf_pkg::PAGE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lrf_pkg::scan_ctl_t             ctl_i,
  input  wire logic [$clog2(FRAME_COUNT)-1:0] idx_i,
  input  wire logic                           valid_i,
  input  wire logic [PAGE_BITS-1:0]           page_i,
  input  wire logic [lrf_pkg::AGE_W-1:0]      age_i,
  input  wire logic [PAGE_BITS-1:0]           ref_page_i,
  output logic                                hit_o,
  output logic                                evict_o,
  output logic      [$clog2(FRAME_COUNT)-1:0] target_o,
  output logic      [PAGE_BITS-1:0]           evict_page_o
);

  localparam int IDX_W = $clog2(FRAME_COUNT);

  logic                      found_q;
  logic                      space_q;
  logic [IDX_W-1:0]          found_idx_q;
  logic [IDX_W-1:0]          space_idx_q;
  logic [IDX_W-1:0]          old_idx_q;
  logic [lrf_pkg::AGE_W-1:0] old_age_q;
  logic [PAGE_BITS-1:0]      old_page_q;

  logic take_hit;
  logic take_space;
  logic take_old;

  assign take_hit   = ctl_i.step && !found_q && valid_i && (page_i == ref_page_i);
  assign take_space = ctl_i.step && !space_q && !valid_i;
  // strict compare keeps the lowest index among equal ages
  assign take_old   = ctl_i.step && ((idx_i == '0) || (age_i > old_age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      space_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
      space_q <= 1'b0;
    end else begin
      if (take_hit) begin
        found_q <= 1'b1;
      end
      if (take_space) begin
        space_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      found_idx_q <= idx_i;
    end
    if (take_space) begin
      space_idx_q <= idx_i;
    end
    if (take_old) begin
      old_idx_q  <= idx_i;
      old_age_q  <= age_i;
      old_page_q <= page_i;
    end
  end

  always_comb begin
    priority if (found_q) begin
      target_o = found_idx_q;
    end else if (space_q) begin
      target_o = space_idx_q;
    end else begin
      target_o = old_idx_q;
    end
  end

  assign hit_o        = found_q;
  assign evict_o      = !found_q && !space_q;
  assign evict_page_o = old_page_q;

endmodule

`default_nettype wire

/* rtl/page_replacement_lru_fifo.sv */
// Page replacement unit, LRU or FIFO policy, over FRAME_COUNT frames.
//
// Input channel: in_valid_i / in_stall_o carry one page reference word
// (page_number_i). Output channel: out_valid_o / out_stall_i carry one
// result word per reference: hit, frame used, evicted page and the
// saturating fault count. A word moves when valid is high and stall low.
// policy_mode sits at APB byte address 0 (0 LRU, 1 FIFO); write it only
// while no reference is in flight.
//
// One compare unit walks the frames one per cycle out of a frame memory
// with registered read: the frame reads are issued in turn, each is compared
// once its read data returns, then the commit step writes the target frame.
// A new reference is not taken until the last one has committed: in_stall_o
// is high from acceptance until the commit cycle is done.
// A stalled result is held in the output register; the next reference may
// be accepted and scanned meanwhile, and its commit waits for the register.
// Reset empties all frames, clears the fault count and selects LRU; the
// memories need no clearing since an empty frame's page and age are never
// used and a load writes both.
`default_nettype none

module page_replacement_lru_fifo #(
  parameter int FRAME_COUNT = lrf_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = lrf_pkg::PAGE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // reference in
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [PAGE_BITS-1:0]               page_number_i,
  // result out
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    hit_o,
  output logic      [lrf_pkg::FRAME_IDX_W-1:0]    frame_index_o,
  output logic                                    evicted_valid_o,
  output logic      [lrf_pkg::EV_PAGE_W-1:0]      evicted_page_o,
  output logic      [lrf_pkg::FAULT_W-1:0]        fault_count_o,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lrf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lrf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [lrf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  lrf_pkg::lrf_state_e state_q, state_d;

  logic [PAGE_BITS-1:0]        ref_page_q, ref_page_d;
  logic [IDX_W-1:0]            issue_idx_q, issue_idx_d;
  logic                        issue_done_q, issue_done_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]            cmp_idx_q, cmp_idx_d;
  logic [FRAME_COUNT-1:0]      valid_q, valid_d;
  logic [lrf_pkg::FAULT_W-1:0] faults_q, faults_d;
  logic                        policy_q, policy_d;
  logic                        out_valid_q, out_valid_d;

  logic                            hit_q, hit_d;
  logic [lrf_pkg::FRAME_IDX_W-1:0] fidx_q, fidx_d;
  logic                            evv_q, evv_d;
  logic [lrf_pkg::EV_PAGE_W-1:0]   evp_q, evp_d;
  logic [lrf_pkg::FAULT_W-1:0]     fcnt_q, fcnt_d;

  // frame memory ports
  logic [PAGE_BITS-1:0]      rd_page;
  logic [lrf_pkg::AGE_W-1:0] rd_age;
  logic                      age_we;
  logic [IDX_W-1:0]          age_waddr;
  logic [lrf_pkg::AGE_W-1:0] age_wdata;
  logic                      page_we;

  // compare unit
  lrf_pkg::scan_ctl_t   scan_ctl;
  logic                 scan_hit;
  logic                 scan_evict;
  logic [IDX_W-1:0]     scan_target;
  logic [PAGE_BITS-1:0] scan_evict_page;

  logic                        apb_wr;
  logic                        reg_sel;
  logic [lrf_pkg::AGE_W-1:0]   age_inc;
  logic [lrf_pkg::FAULT_W-1:0] fault_inc;
  logic [IDX_W+lrf_pkg::FRAME_IDX_W-1:0] target_ext;
  logic [PAGE_BITS+lrf_pkg::EV_PAGE_W-1:0] evict_ext;

  lrf_frame_mem #(
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_BITS  (PAGE_BITS)
  ) u_mem (
    .clk_i       (clk_i),
    .rd_addr_i   (issue_idx_q),
    .rd_page_o   (rd_page),
    .rd_age_o    (rd_age),
    .age_we_i    (age_we),
    .age_waddr_i (age_waddr),
    .age_wdata_i (age_wdata),
    .page_we_i   (page_we),
    .page_waddr_i(scan_target),
    .page_wdata_i(ref_page_q)
  );

  lrf_scan_unit #(
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_BITS  (PAGE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .idx_i       (cmp_idx_q),
    .valid_i     (valid_q[cmp_idx_q]),
    .page_i      (rd_page),
    .age_i       (rd_age),
    .ref_page_i  (ref_page_q),
    .hit_o       (scan_hit),
    .evict_o     (scan_evict),
    .target_o    (scan_target),
    .evict_page_o(scan_evict_page)
  );

  assign apb_wr  = psel && penable && pwrite;
  assign reg_sel = (paddr[lrf_pkg::CFG_ADDR_W-1:2] == lrf_pkg::REG_POLICY_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? lrf_pkg::CFG_DATA_W'(policy_q) : '0;

  assign age_inc   = (rd_age == lrf_pkg::AGE_MAX) ? rd_age : rd_age + lrf_pkg::AGE_W'(1);
  assign fault_inc = (faults_q == lrf_pkg::FAULT_MAX) ? faults_q
                                                      : faults_q + lrf_pkg::FAULT_W'(1);
  assign target_ext = (IDX_W + lrf_pkg::FRAME_IDX_W)'(scan_target);
  assign evict_ext  = (PAGE_BITS + lrf_pkg::EV_PAGE_W)'(scan_evict_page);

  always_comb begin
    state_d      = state_q;
    ref_page_d   = ref_page_q;
    issue_idx_d  = issue_idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    valid_d      = valid_q;
    faults_d     = faults_q;
    policy_d     = policy_q;
    out_valid_d  = out_valid_q;
    hit_d        = hit_q;
    fidx_d       = fidx_q;
    evv_d        = evv_q;
    evp_d        = evp_q;
    fcnt_d       = fcnt_q;
    scan_ctl     = '0;
    age_we       = 1'b0;
    age_waddr    = cmp_idx_q;
    age_wdata    = age_inc;
    page_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (apb_wr && reg_sel) begin
      policy_d = pwdata[0];
    end

    unique case (state_q)
      lrf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ref_page_d     = page_number_i;
          issue_idx_d    = '0;
          issue_done_d   = 1'b0;
          scan_ctl.clear = 1'b1;
          state_d        = lrf_pkg::ST_SCAN;
        end
      end
      lrf_pkg::ST_SCAN: begin
        // issue one read per cycle, compare it in the next cycle
        if (!issue_done_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_idx_q;
          if (issue_idx_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end else begin
            issue_idx_d = issue_idx_q + IDX_W'(1);
          end
        end
        if (cmp_vld_q) begin
          scan_ctl.step = 1'b1;
          // age every frame now; at commit the target age is cleared on a miss or an LRU hit
          age_we = 1'b1;
          if (cmp_idx_q == LAST_IDX) begin
            state_d = lrf_pkg::ST_COMMIT;
          end
        end
      end
      lrf_pkg::ST_COMMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          age_waddr = scan_target;
          age_wdata = '0;
          age_we    = !scan_hit || (policy_q == lrf_pkg::POLICY_LRU);
          if (!scan_hit) begin
            page_we              = 1'b1;
            valid_d[scan_target] = 1'b1;
            faults_d             = fault_inc;
          end
          hit_d       = scan_hit;
          fidx_d      = target_ext[lrf_pkg::FRAME_IDX_W-1:0];
          evv_d       = scan_evict;
          evp_d       = scan_evict ? evict_ext[lrf_pkg::EV_PAGE_W-1:0] : '0;
          fcnt_d      = scan_hit ? faults_q : fault_inc;
          out_valid_d = 1'b1;
          state_d     = lrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lrf_pkg::ST_IDLE;
      issue_idx_q  <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      valid_q      <= '0;
      faults_q     <= '0;
      policy_q     <= lrf_pkg::POLICY_LRU;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_idx_q  <= issue_idx_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      valid_q      <= valid_d;
      faults_q     <= faults_d;
      policy_q     <= policy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_page_q <= ref_page_d;
    hit_q      <= hit_d;
    fidx_q     <= fidx_d;
    evv_q      <= evv_d;
    evp_q      <= evp_d;
    fcnt_q     <= fcnt_d;
  end

  assign in_stall_o      = (state_q != lrf_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = evv_q;
  assign evicted_page_o  = evp_q;
  assign fault_count_o   = fcnt_q;

endmodule

`default_nettype wire

/* rtl/lrf_checker.sv */
`default_nettype none

module lrf_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic                               hit_o,
  input wire logic [lrf_pkg::FRAME_IDX_W-1:0]    frame_index_o,
  input wire logic                               evicted_valid_o,
  input wire logic [lrf_pkg::EV_PAGE_W-1:0]      evicted_page_o,
  input wire logic [lrf_pkg::FAULT_W-1:0]        fault_count_o
);

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit reported together with an eviction");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without eviction");

  // an accepted reference keeps the input side busy while it is scanned
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a reference");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hit_o) &&
      $stable(frame_index_o) && $stable(evicted_valid_o) &&
      $stable(evicted_page_o) && $stable(fault_count_o)))
    else $error("stalled result word changed");

endmodule

bind page_replacement_lru_fifo lrf_checker u_lrf_checker (.*);

`default_nettype wire

/* tb/sv/page_ref_checker.sv */
`timescale 1ns / 100ps

module page_ref_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_stall_o,
  input  wire logic [lrf_pkg::PAGE_BITS_DEF-1:0] page_number_i,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  input  wire logic                             hit_o,
  input  wire logic [lrf_pkg::FRAME_IDX_W-1:0]  frame_index_o,
  input  wire logic                             evicted_valid_o,
  input  wire logic [lrf_pkg::EV_PAGE_W-1:0]    evicted_page_o,
  input  wire logic [lrf_pkg::FAULT_W-1:0]      fault_count_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lrf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [lrf_pkg::CFG_DATA_W-1:0]   pwdata,
  input  wire logic [lrf_pkg::CFG_DATA_W-1:0]   prdata,
  input  wire logic                             pready,
  output int                                    fail_count,
  output int                                    pending
);
  import lrf_pkg::*;

  localparam int NFRAMES = FRAME_COUNT_DEF;
  localparam int PBITS   = PAGE_BITS_DEF;
  localparam logic [CFG_ADDR_W-1:0] POLICY_ADDR = {REG_POLICY_MODE, 2'b00};

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   ev_valid;
    logic [EV_PAGE_W-1:0]   ev_page;
    logic [FAULT_W-1:0]     faults;
  } page_result_t;

  logic [PBITS-1:0]   fr_page [NFRAMES];
  logic               fr_used [NFRAMES];
  logic [AGE_W-1:0]   fr_age  [NFRAMES];
  logic [FAULT_W-1:0] faults;
  logic               policy;
  page_result_t       due_results [$];
  page_result_t       want;
  int                 nerr;

  // Resolve one reference against the frame table and advance the ages.
  function automatic page_result_t replace_page(input logic [PBITS-1:0] pg);
    page_result_t r;
    int           tgt;
    bit           refresh;
    r       = '0;
    tgt     = -1;
    refresh = 1'b0;
    for (int i = 0; i < NFRAMES; i++)
      if (tgt < 0 && fr_used[i] && fr_page[i] == pg) tgt = i;
    if (tgt >= 0) begin
      r.hit   = 1'b1;
      refresh = (policy == POLICY_LRU);
    end else begin
      for (int i = 0; i < NFRAMES; i++)
        if (tgt < 0 && !fr_used[i]) tgt = i;
      if (tgt < 0) begin
        // table full: oldest frame goes, lowest index on a tie
        tgt = 0;
        for (int i = 1; i < NFRAMES; i++)
          if (fr_age[i] > fr_age[tgt]) tgt = i;
        r.ev_valid = 1'b1;
        r.ev_page  = fr_page[tgt][EV_PAGE_W-1:0];
      end
      fr_page[tgt] = pg;
      fr_used[tgt] = 1'b1;
      refresh      = 1'b1;
      if (faults != FAULT_MAX) faults = faults + 1'b1;
    end
    for (int i = 0; i < NFRAMES; i++) begin
      if (i == tgt && refresh) fr_age[i] = '0;
      else if (fr_age[i] != AGE_MAX) fr_age[i] = fr_age[i] + 1'b1;
    end
    r.frame  = tgt[FRAME_IDX_W-1:0];
    r.faults = faults;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      nerr++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NFRAMES; i++) begin
        fr_page[i] = '0;
        fr_used[i] = 1'b0;
        fr_age[i]  = '0;
      end
      faults = '0;
      policy = POLICY_LRU;
      nerr   = 0;
      due_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // retire before accept: a result word never belongs to the word taken this edge
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with none expected, got hit %0h frame %0h ev %0h/%0h cnt %0h",
                   $time, hit_o, frame_index_o, evicted_valid_o, evicted_page_o,
                   fault_count_o);
          nerr++;
        end else begin
          want = due_results.pop_front();
          compare_field("hit", 32'(want.hit), 32'(hit_o));
          compare_field("frame_index", 32'(want.frame), 32'(frame_index_o));
          compare_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid_o));
          compare_field("evicted_page", 32'(want.ev_page), 32'(evicted_page_o));
          compare_field("fault_count", 32'(want.faults), 32'(fault_count_o));
        end
      end
      if (in_valid_i && !in_stall_o)
        due_results.push_back(replace_page(page_number_i));
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == POLICY_ADDR) policy = pwdata[0];
        end else if (paddr == POLICY_ADDR) begin
          compare_field("prdata", {{(CFG_DATA_W-1){1'b0}}, policy}, prdata);
        end
      end
      fail_count <= nerr;
      pending    <= due_results.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lrf_pkg::*;

  localparam int WATCHDOG     = 4000;
  localparam int DRAIN_CYCLES = 2 * FRAME_COUNT_DEF + 8;
  localparam int PHASE_ITEMS  = 300;
  localparam int LONG_HOLD    = 400;
  localparam logic [CFG_ADDR_W-1:0] ADDR_POLICY   = {REG_POLICY_MODE, 2'b00};
  // register index 1 has nothing behind it
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = {~REG_POLICY_MODE, 2'b00};

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [PAGE_BITS_DEF-1:0]   page_number_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic                       hit_o;
  logic [FRAME_IDX_W-1:0]     frame_index_o;
  logic                       evicted_valid_o;
  logic [EV_PAGE_W-1:0]       evicted_page_o;
  logic [FAULT_W-1:0]         fault_count_o;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr         = '0;
  logic [CFG_DATA_W-1:0]      pwdata        = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;
  int                         fail_count;
  int                         pending;
  bit                         hold_due      = 1'b0;
  int unsigned                quiet_cycles  = 0;

  page_replacement_lru_fifo dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .page_number_i(page_number_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .hit_o(hit_o),
    .frame_index_o(frame_index_o), .evicted_valid_o(evicted_valid_o),
    .evicted_page_o(evicted_page_o), .fault_count_o(fault_count_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  page_ref_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .page_number_i(page_number_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .hit_o(hit_o),
    .frame_index_o(frame_index_o), .evicted_valid_o(evicted_valid_o),
    .evicted_page_o(evicted_page_o), .fault_count_o(fault_count_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // most references stay near a working set slightly larger than the table
  function automatic logic [PAGE_BITS_DEF-1:0] pick_page(input logic [PAGE_BITS_DEF-1:0] base);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return PAGE_BITS_DEF'(base + $urandom_range(0, FRAME_COUNT_DEF + 1));
    if (r < 85) return PAGE_BITS_DEF'(base + $urandom_range(0, 4 * FRAME_COUNT_DEF));
    return PAGE_BITS_DEF'($urandom);
  endfunction

  task automatic offer_page(input logic [PAGE_BITS_DEF-1:0] pg, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i    <= 1'b0;
      page_number_i <= PAGE_BITS_DEF'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait until every result word has come back
  task automatic end_burst();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus idle between transfers
    @(posedge clk_i);
  endtask

  // write the policy with junk in the upper bits, then read it back and read one random address
  task automatic set_policy(input logic pol);
    logic [CFG_DATA_W-1:0] w;
    w    = $urandom;
    w[0] = pol;
    apb_access(1'b1, ADDR_POLICY, w);
    apb_access(1'b0, ADDR_POLICY, '0);
    apb_access(1'b0, CFG_ADDR_W'($urandom_range(0, 7)), '0);
  endtask

  task automatic run_phase(input logic pol, input int unsigned items, input bit with_hold);
    logic [PAGE_BITS_DEF-1:0] base;
    set_policy(pol);
    base = PAGE_BITS_DEF'($urandom);
    for (int unsigned k = 0; k < items; k++) begin
      if (k % 40 == 0) base = PAGE_BITS_DEF'($urandom);
      if (with_hold && k == items / 2) hold_due = 1'b1;
      offer_page(pick_page(base), gap_len());
    end
    end_burst();
  endtask

  // receiver: random stalls, one long hold on request
  initial begin : rx_side
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = gap_len();
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(50, 200);
      else n = $urandom_range(1, 12);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : stim
    logic [PAGE_BITS_DEF-1:0] lru_seq [11];
    logic [PAGE_BITS_DEF-1:0] fifo_seq [10];
    lru_seq  = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                 8'h00, 8'h07, 8'hFF};
    fifo_seq = '{8'h00, 8'h07, 8'h08, 8'h09, 8'h00, 8'h0A, 8'hAA, 8'h55,
                 8'h0B, 8'h08};
    @(posedge rst_ni);
    apb_access(1'b0, ADDR_POLICY, '0);

    // fill the empty table, hit to refresh, then evict the oldest
    foreach (lru_seq[k]) offer_page(lru_seq[k], gap_len());
    end_burst();

    set_policy(POLICY_FIFO);
    apb_access(1'b1, ADDR_UNMAPPED, '0);
    apb_access(1'b0, ADDR_POLICY, '0);
    foreach (fifo_seq[k]) offer_page(fifo_seq[k], gap_len());
    end_burst();

    run_phase(POLICY_LRU, PHASE_ITEMS, 1'b0);
    run_phase(POLICY_FIFO, PHASE_ITEMS, 1'b1);
    run_phase(POLICY_LRU, PHASE_ITEMS, 1'b0);
    run_phase(POLICY_FIFO, PHASE_ITEMS, 1'b0);

    run_phase(POLICY_FIFO, 40, 1'b0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: cycles in a row with no word, no register access
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* page_replacement_lru_fifo.f */
rtl/lrf_pkg.sv
rtl/lrf_frame_mem.sv
rtl/lrf_scan_unit.sv
rtl/page_replacement_lru_fifo.sv
rtl/lrf_checker.sv
tb/sv/page_ref_checker.sv
tb/sv/testbench.sv
